// ----- rtl/core/vbmm_pkg.sv -----
`timescale 1ns / 1ps

package vbmm_pkg;

  localparam int unsigned NametableBytes = 2048;
  localparam int unsigned PaletteBytes   = 32;

  localparam int unsigned BusAw   = 14;
  localparam int unsigned IndexW  = 13;
  localparam int unsigned DataW   = 8;
  localparam int unsigned TargetW = 2;

  typedef logic [TargetW-1:0] target_t;

  localparam target_t TgtPattern   = 2'd0;
  localparam target_t TgtNametable = 2'd1;
  localparam target_t TgtPalette   = 2'd2;

  localparam logic [BusAw-1:0] NtBase  = 14'h2000;
  localparam logic [BusAw-1:0] PalBase = 14'h3F00;

  localparam logic [4:0] PalAliasMask = 5'h13;
  localparam logic [4:0] PalAliasHit  = 5'h10;

  typedef struct packed {
    logic              rd_nt;
    logic              rd_pal;
    target_t           target;
    logic [IndexW-1:0] index;
    logic              rejected;
  } vbmm_slot_t;

endpackage

// ----- rtl/core/vbmm_ram.sv -----
`timescale 1ns / 1ps

module vbmm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/video_bus_memory_map_core.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake               Payload
// in       in         in_valid_i / in_stall_o  req_type_i, address_i, write_data_i
// out      out        out_valid_o / out_stall_i
//                                              read_data_o, target_o, mapped_index_o,
//                                              rejected_write_o
// cfg      in         cfg_we_i                 cfg_wdata_i (mirror mode)
//
// One request is taken per cycle while in_stall_o is low; its result passes through the
// stage-one register (beside the registered RAM read port) and then the output register.
// Reset clears the mirror mode and the valid flags; the RAM contents stay undefined.
// A stalled output holds its result, and the input stalls only when the pending
// stage-one request cannot move into the output register.

module video_bus_memory_map_core
  import vbmm_pkg::*;
#(
  parameter int unsigned NtBytes  = NametableBytes,
  parameter int unsigned PalBytes = PaletteBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [15:0]       address_i,
  input  logic [DataW-1:0]  write_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DataW-1:0]  read_data_o,
  output target_t           target_o,
  output logic [IndexW-1:0] mapped_index_o,
  output logic              rejected_write_o
);

  localparam int unsigned NtAw  = $clog2(NtBytes);
  localparam int unsigned PalAw = $clog2(PalBytes);

  logic             mode_q;
  logic             s1_valid_q;
  vbmm_slot_t       s1_q, s1_d;
  logic             out_valid_q;
  logic [DataW-1:0] rdata_q, rdata_d;
  vbmm_slot_t       out_q;

  logic             accept;
  logic             out_free;
  logic             s1_move;
  logic [BusAw-1:0] addr;
  logic             page;
  logic [NtAw-1:0]  nt_idx;
  logic [PalAw-1:0] pal_idx;
  logic             nt_en;
  logic             pal_en;
  logic [DataW-1:0] nt_rdata;
  logic [DataW-1:0] pal_rdata;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign addr = address_i[BusAw-1:0];
  assign page = mode_q ? addr[11] : addr[10];

  always_comb begin
    nt_idx = {page, addr[NtAw-2:0]};
    pal_idx = addr[PalAw-1:0];
    if ((addr[4:0] & PalAliasMask) == PalAliasHit) begin
      pal_idx[4] = 1'b0;
    end
  end

  always_comb begin
    s1_d          = '0;
    s1_d.rejected = 1'b0;
    nt_en         = 1'b0;
    pal_en        = 1'b0;
    if (addr < NtBase) begin
      s1_d.target   = TgtPattern;
      s1_d.index    = addr[IndexW-1:0];
      s1_d.rejected = req_type_i;
    end else if (addr < PalBase) begin
      s1_d.target = TgtNametable;
      s1_d.index  = IndexW'(nt_idx);
      s1_d.rd_nt  = !req_type_i;
      nt_en       = accept;
    end else begin
      s1_d.target = TgtPalette;
      s1_d.index  = IndexW'(pal_idx);
      s1_d.rd_pal = !req_type_i;
      pal_en      = accept;
    end
  end

  vbmm_ram #(
    .Width (DataW),
    .Depth (NtBytes)
  ) u_nt_ram (
    .clk_i   (clk_i),
    .en_i    (nt_en),
    .we_i    (req_type_i),
    .addr_i  (nt_idx),
    .wdata_i (write_data_i),
    .rdata_o (nt_rdata)
  );

  vbmm_ram #(
    .Width (DataW),
    .Depth (PalBytes)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .en_i    (pal_en),
    .we_i    (req_type_i),
    .addr_i  (pal_idx),
    .wdata_i (write_data_i),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    rdata_d = '0;
    if (s1_q.rd_nt) begin
      rdata_d = nt_rdata;
    end else if (s1_q.rd_pal) begin
      rdata_d = pal_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      out_q   <= s1_q;
      rdata_q <= rdata_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = rdata_q;
  assign target_o         = out_q.target;
  assign mapped_index_o   = out_q.index;
  assign rejected_write_o = out_q.rejected;

endmodule

// ----- rtl/core/vbmm_checker.sv -----
`timescale 1ns / 1ps

module vbmm_checker
  import vbmm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DataW-1:0]  read_data_o,
  input target_t           target_o,
  input logic [IndexW-1:0] mapped_index_o,
  input logic              rejected_write_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ##1 out_valid_o)
    else $error("Accepted request produced no result.");

  a_reject_pattern_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_write_o) |-> (target_o == TgtPattern && read_data_o == '0))
    else $error("Rejected write outside the pattern region.");

  a_pattern_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && target_o == TgtPattern) |-> (read_data_o == '0))
    else $error("Pattern access returned data.");

  a_palette_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && target_o == TgtPalette) |->
      (mapped_index_o < IndexW'(PaletteBytes) && !rejected_write_o))
    else $error("Palette index out of range.");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(mapped_index_o)))
    else $error("Stalled result changed.");

endmodule

bind video_bus_memory_map_core vbmm_checker u_vbmm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .read_data_o      (read_data_o),
  .target_o         (target_o),
  .mapped_index_o   (mapped_index_o),
  .rejected_write_o (rejected_write_o)
);

// ----- dv/video_bus_memory_map_core_tb.sv -----
`timescale 1ns / 1ps

module video_bus_memory_map_core_tb;
  import vbmm_pkg::*;

  localparam logic ReqRead  = 1'b0;
  localparam logic ReqWrite = 1'b1;

  localparam int unsigned Phases        = 6;
  localparam int unsigned PhaseItems    = 237;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DirectedCount = 27;

  typedef struct packed {
    logic [DataW-1:0]  read_data;
    target_t           target;
    logic [IndexW-1:0] index;
    logic              rejected;
  } access_result_t;

  typedef enum logic {RowAccess, RowMirror} row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    logic           req;
    logic [15:0]    addr;
    logic [7:0]     data;
    logic           typed;
    access_result_t result;
  } stim_row_t;

  localparam access_result_t NoResult = '0;

  localparam stim_row_t DirectedRows [DirectedCount] = '{
    '{RowAccess, ReqRead,  16'h0000, 8'h00, 1'b1, '{8'h00, TgtPattern,   13'h0000, 1'b0}},
    '{RowAccess, ReqWrite, 16'h1FFF, 8'hFF, 1'b1, '{8'h00, TgtPattern,   13'h1FFF, 1'b1}},
    '{RowAccess, ReqWrite, 16'hFFFF, 8'hA5, 1'b1, '{8'h00, TgtPalette,   13'h001F, 1'b0}},
    '{RowAccess, ReqRead,  16'h3FFF, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqWrite, 16'h2000, 8'h11, 1'b1, '{8'h00, TgtNametable, 13'h0000, 1'b0}},
    '{RowAccess, ReqWrite, 16'h2400, 8'h22, 1'b0, NoResult},
    '{RowAccess, ReqRead,  16'h2800, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqRead,  16'h2C00, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqWrite, 16'h23FF, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqRead,  16'h3BFF, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqWrite, 16'h2FFF, 8'h5A, 1'b0, NoResult},
    '{RowAccess, ReqWrite, 16'h3EFF, 8'hC3, 1'b0, NoResult},
    '{RowAccess, ReqRead,  16'h2EFF, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqRead,  16'hAFFF, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqWrite, 16'h3F10, 8'h77, 1'b1, '{8'h00, TgtPalette,   13'h0000, 1'b0}},
    '{RowAccess, ReqRead,  16'h3F00, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqWrite, 16'h3F1C, 8'h88, 1'b1, '{8'h00, TgtPalette,   13'h000C, 1'b0}},
    '{RowAccess, ReqRead,  16'h7F2C, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqWrite, 16'h3F14, 8'h5F, 1'b1, '{8'h00, TgtPalette,   13'h0004, 1'b0}},
    '{RowAccess, ReqWrite, 16'h3F18, 8'h0F, 1'b1, '{8'h00, TgtPalette,   13'h0008, 1'b0}},
    '{RowAccess, ReqRead,  16'hC000, 8'h00, 1'b1, '{8'h00, TgtPattern,   13'h0000, 1'b0}},
    '{RowMirror, ReqRead,  16'h0000, 8'h01, 1'b0, NoResult},
    '{RowAccess, ReqRead,  16'h2400, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqRead,  16'h2800, 8'h00, 1'b0, NoResult},
    '{RowAccess, ReqWrite, 16'h3C00, 8'hE1, 1'b0, NoResult},
    '{RowAccess, ReqRead,  16'h2C00, 8'h00, 1'b0, NoResult},
    '{RowMirror, ReqRead,  16'h0000, 8'h00, 1'b0, NoResult}
  };

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              cfg_we_i         = 1'b0;
  logic              cfg_wdata_i      = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic              req_type_i       = 1'b0;
  logic [15:0]       address_i        = '0;
  logic [DataW-1:0]  write_data_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [DataW-1:0]  read_data_o;
  target_t           target_o;
  logic [IndexW-1:0] mapped_index_o;
  logic              rejected_write_o;

  logic           mirror_mode_q = 1'b0;
  logic [7:0]     nt_image  [NametableBytes];
  logic [7:0]     pal_image [PaletteBytes];
  bit             nt_written  [NametableBytes];
  bit             pal_written [PaletteBytes];
  logic [10:0]    nt_written_list [$];
  logic [4:0]     pal_written_list [$];
  logic [10:0]    last_nt_idx;
  logic [4:0]     last_pal_idx;
  access_result_t pending_results [$];
  int unsigned    mismatches   = 0;
  bit             tx_calm      = 1'b0;

  int unsigned    results_seen = 0;
  int unsigned    rx_wait      = 0;
  int unsigned    rx_hold      = 0;
  bit             rx_stall_next;
  access_result_t rx_want;
  int unsigned    idle_cycles  = 0;

  video_bus_memory_map_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_data_o      (read_data_o),
    .target_o         (target_o),
    .mapped_index_o   (mapped_index_o),
    .rejected_write_o (rejected_write_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  function automatic access_result_t map_access(input logic req, input logic [15:0] addr,
                                                input logic [7:0] data);
    access_result_t res;
    logic [13:0]    bus;
    logic [1:0]     quad;
    logic           page;
    logic [10:0]    nt_idx;
    logic [4:0]     pal_idx;
    res = '0;
    bus = addr[13:0];
    if (bus < NtBase) begin
      res.target   = TgtPattern;
      res.index    = bus[IndexW-1:0];
      res.rejected = (req == ReqWrite);
    end else if (bus < PalBase) begin
      quad   = bus[11:10];
      page   = mirror_mode_q ? quad[1] : quad[0];
      nt_idx = {page, bus[9:0]};
      res.target = TgtNametable;
      res.index  = IndexW'(nt_idx);
      if (req == ReqWrite) begin
        nt_image[nt_idx] = data;
        if (!nt_written[nt_idx]) begin
          nt_written[nt_idx] = 1'b1;
          nt_written_list.push_back(nt_idx);
        end
        last_nt_idx = nt_idx;
      end else begin
        res.read_data = nt_image[nt_idx];
      end
    end else begin
      pal_idx = bus[4:0];
      if ((pal_idx & PalAliasMask) == PalAliasHit) begin
        pal_idx[4] = 1'b0;
      end
      res.target = TgtPalette;
      res.index  = IndexW'(pal_idx);
      if (req == ReqWrite) begin
        pal_image[pal_idx] = data;
        if (!pal_written[pal_idx]) begin
          pal_written[pal_idx] = 1'b1;
          pal_written_list.push_back(pal_idx);
        end
        last_pal_idx = pal_idx;
      end else begin
        res.read_data = pal_image[pal_idx];
      end
    end
    return res;
  endfunction

  task automatic send_access(input logic req, input logic [15:0] addr, input logic [7:0] data,
                             input logic typed, input access_result_t typed_result);
    int unsigned    gap;
    access_result_t predicted;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    address_i    <= addr;
    write_data_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = map_access(req, addr, data);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mirror_mode(input logic mode);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    mirror_mode_q = mode;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending", 16'(mapped_index_o), 16'h0);
        end else begin
          rx_want = pending_results.pop_front();
          if (read_data_o !== rx_want.read_data) begin
            report_mismatch("read_data", 16'(read_data_o), 16'(rx_want.read_data));
          end
          if (target_o !== rx_want.target) begin
            report_mismatch("target", 16'(target_o), 16'(rx_want.target));
          end
          if (mapped_index_o !== rx_want.index) begin
            report_mismatch("mapped_index", 16'(mapped_index_o), 16'(rx_want.index));
          end
          if (rejected_write_o !== rx_want.rejected) begin
            report_mismatch("rejected_write", 16'(rejected_write_o), 16'(rx_want.rejected));
          end
        end
        results_seen++;
        rx_wait = ((results_seen % 256) < 48) ? 0 : $urandom_range(0, 3);
        if (results_seen == 300 || results_seen == 1000) begin
          rx_hold = 64;
        end
      end
      if (rx_hold != 0) begin
        rx_hold--;
        rx_stall_next = 1'b1;
      end else if (rx_wait != 0) begin
        rx_wait--;
        rx_stall_next = 1'b1;
      end else begin
        rx_stall_next = 1'b0;
      end
      out_stall_i <= rx_stall_next;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned pick;
    logic        req;
    logic [13:0] bus;
    logic [1:0]  quad;
    logic [10:0] nt_sel;
    logic [4:0]  pal_sel;
    stim_row_t   row;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < DirectedCount; n++) begin
      row = DirectedRows[n];
      if (row.kind == RowMirror) begin
        write_mirror_mode(row.data[0]);
      end else begin
        send_access(row.req, row.addr, row.data, row.typed, row.result);
      end
    end

    for (phase = 0; phase < Phases; phase++) begin
      write_mirror_mode(~phase[0]);
      for (n = 0; n < PhaseItems; n++) begin
        tx_calm = (n % 120) < 25;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          req = $urandom_range(0, 1);
          bus = 14'($urandom_range(0, 'h1FFF));
        end else if (pick < 60) begin
          req = (nt_written_list.size() == 0) || ($urandom_range(0, 99) < 45);
          if (req == ReqWrite) begin
            bus = NtBase + 14'($urandom_range(0, 'h1EFF));
          end else begin
            if ($urandom_range(0, 99) < 30) begin
              nt_sel = last_nt_idx;
            end else begin
              nt_sel = nt_written_list[$urandom_range(0, nt_written_list.size() - 1)];
            end
            quad = mirror_mode_q ? {nt_sel[10], 1'($urandom_range(0, 1))}
                                 : {1'($urandom_range(0, 1)), nt_sel[10]};
            if ({quad, nt_sel[9:0]} < 12'hF00 && $urandom_range(0, 1) == 1) begin
              bus = {2'b11, quad, nt_sel[9:0]};
            end else begin
              bus = {2'b10, quad, nt_sel[9:0]};
            end
          end
        end else begin
          req = (pal_written_list.size() == 0) || ($urandom_range(0, 99) < 45);
          if (req == ReqWrite) begin
            bus = PalBase + 14'($urandom_range(0, 'hFF));
          end else begin
            if ($urandom_range(0, 99) < 30) begin
              pal_sel = last_pal_idx;
            end else begin
              pal_sel = pal_written_list[$urandom_range(0, pal_written_list.size() - 1)];
            end
            if ((pal_sel & PalAliasMask) == 5'h00 && $urandom_range(0, 1) == 1) begin
              pal_sel[4] = 1'b1;
            end
            bus = {6'b111111, 3'($urandom_range(0, 7)), pal_sel};
          end
        end
        send_access(req, {2'($urandom_range(0, 3)), bus}, 8'($urandom_range(0, 255)),
                    1'b0, NoResult);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never returned", 16'(pending_results.size()), 16'h0);
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/vbmm_pkg.sv
rtl/core/vbmm_ram.sv
rtl/core/video_bus_memory_map_core.sv
rtl/core/vbmm_checker.sv
dv/video_bus_memory_map_core_tb.sv
